@@ sv/srre_pkg.sv @@
// ---------------------------------------------------------------------------
// srre_pkg
// Shared constants, codes and controller/datapath interface types for the
// sprite row run-length encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package srre_pkg;

    localparam int MAX_ROW   = 4096;
    localparam int ZERO_CAP  = (MAX_ROW < 8191) ? MAX_ROW : 8191;
    localparam int ZP_W      = 13;
    localparam int LIT_DEPTH = 127;
    localparam int LIT_AW    = 7;
    localparam int IN_W      = 8;
    localparam int WORD_W    = 64;
    localparam int CNT_W     = 4;
    localparam int OUT_W     = 72;

    localparam logic [ZP_W-1:0]   ZP_CAP    = ZP_W'(ZERO_CAP);
    localparam logic [ZP_W-1:0]   ZP_RUN    = ZP_W'(8'h7F);
    localparam logic [LIT_AW-1:0] RUN_MAX   = 7'h7F;
    localparam logic [7:0]        ZERO_FLAG = 8'h80;
    localparam logic [CNT_W-1:0]  FILL_FULL = 4'd8;

    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_COUNT = 2'd1,
        SRC_DATA  = 2'd2,
        SRC_MARK  = 2'd3
    } t_src;

    typedef struct packed {
        logic take;
        logic zp_inc;
        logic zp_sub;
        logic zp_clr;
        logic store;
        logic push;
        t_src src;
        logic idx_clr;
        logic idx_inc;
        logic cnt_clr;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic has;
        logic px_zero;
        logic eor;
        logic zp_nz;
        logic zp_last;
        logic cnt_nz;
        logic cnt_full;
        logic idx_last;
        logic byte_ok;
        logic close_ok;
    } t_status;

endpackage

`default_nettype wire

@@ sv/sprite_row_rle_encoder.sv @@
// ---------------------------------------------------------------------------
// sprite_row_rle_encoder
// Transparent run-length encoder for sprite rows, bytes packed eight a beat.
//
// Input stream: one pixel per beat in tdata, tuser = has_pixel, tlast marks
// the end of the row. Output stream: tdata carries up to eight encoded bytes
// (first byte in bits 7..0) and the valid byte count in bits 67..64; tlast
// marks the final output beat caused by an input beat. A beat that encodes
// nothing gives no output beat.
// Each input beat is accepted and then decoded; if it emits bytes, they are
// packed one byte per cycle while the packer is not held by a full word
// waiting on the receiver, a pixel is stored after a zero or full-literal
// flush, and the last word is closed. A literal flush sends its count and
// then each pixel through the single read port of the literal memory.
// A word enters the output register only when it is full and the next byte
// is packed, or when it is closed.
// Reset clears the zero-run counter, the literal count and both streams.
// When the receiver stalls, the output register holds its beat and the
// encoder stops at the next full word; input is taken again once the
// current beat has been fully encoded.
// ---------------------------------------------------------------------------
`default_nettype none

module sprite_row_rle_encoder
    import srre_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // pixel[7:0]
    input  wire logic             s_axis_tuser,   // has_pixel
    input  wire logic             s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // packed_bytes[63:0], byte_count[67:64]
    output logic                  m_axis_tlast
);

    t_cmd              cmd;
    t_status           st;
    logic [WORD_W-1:0] packed_bytes;
    logic [CNT_W-1:0]  byte_count;

    srre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    srre_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_pixel        (s_axis_tdata),
        .i_has_pixel    (s_axis_tuser),
        .i_end_of_row   (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_packed_bytes (packed_bytes),
        .o_byte_count   (byte_count),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_W-WORD_W-CNT_W){1'b0}}, byte_count, packed_bytes};

    a_zero_run_no_literals : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && st.zp_nz) |-> !st.cnt_nz
    ) else $error("zero run pending while literals held");

    a_count_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (byte_count != '0) && (byte_count <= FILL_FULL)
    ) else $error("output byte count out of range");

    a_inner_word_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (byte_count == FILL_FULL)
    ) else $error("non-final output word not full");

    a_no_input_while_busy : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push || cmd.close || cmd.store) |-> !s_axis_tready
    ) else $error("input ready while encoding");

endmodule

`default_nettype wire

@@ sv/srre_ctrl.sv @@
// ---------------------------------------------------------------------------
// srre_ctrl
// Controller: accepts one pixel item at a time and sequences the byte
// sources (zero codes, literal count, literal data, row mark) and the close.
// ---------------------------------------------------------------------------
`default_nettype none

module srre_ctrl
    import srre_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DECODE    = 8'b0000_0010,
        ST_ZERO_EMIT = 8'b0000_0100,
        ST_LIT_COUNT = 8'b0000_1000,
        ST_LIT_DATA  = 8'b0001_0000,
        ST_STORE     = 8'b0010_0000,
        ST_EOR_MARK  = 8'b0100_0000,
        ST_CLOSE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_CLOSE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_st.has && i_st.px_zero) begin
                    o_cmd.zp_inc = 1'b1;
                    if (i_st.cnt_nz) begin
                        n_ret   = i_st.eor ? ST_EOR_MARK : ST_CLOSE;
                        n_state = ST_LIT_COUNT;
                    end else begin
                        n_state = i_st.eor ? ST_EOR_MARK : ST_IDLE;
                    end
                end else if (i_st.has) begin
                    if (i_st.zp_nz) begin
                        n_state = ST_ZERO_EMIT;
                    end else if (i_st.cnt_full) begin
                        n_ret   = ST_STORE;
                        n_state = ST_LIT_COUNT;
                    end else begin
                        o_cmd.store = 1'b1;
                        if (i_st.eor) begin
                            n_ret   = ST_EOR_MARK;
                            n_state = ST_LIT_COUNT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (i_st.eor) begin
                    if (i_st.cnt_nz) begin
                        n_ret   = ST_EOR_MARK;
                        n_state = ST_LIT_COUNT;
                    end else begin
                        n_state = ST_EOR_MARK;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ZERO_EMIT: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_ZERO;
                if (i_st.byte_ok) begin
                    o_cmd.zp_sub = 1'b1;
                    if (i_st.zp_last) begin
                        n_state = ST_STORE;
                    end
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                if (i_st.eor) begin
                    n_ret   = ST_EOR_MARK;
                    n_state = ST_LIT_COUNT;
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_LIT_COUNT: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_COUNT;
                if (i_st.byte_ok) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_LIT_DATA;
                end
            end
            ST_LIT_DATA: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_DATA;
                if (i_st.byte_ok) begin
                    if (i_st.idx_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = r_ret;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_EOR_MARK: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_MARK;
                if (i_st.byte_ok) begin
                    o_cmd.zp_clr = 1'b1;
                    n_state      = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
                if (i_st.close_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/srre_datapath.sv @@
// ---------------------------------------------------------------------------
// srre_datapath
// Datapath: item register, zero-run counter, literal memory and count,
// byte source select, eight-byte packer and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module srre_datapath
    import srre_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_status              o_st,
    input  wire logic [IN_W-1:0] i_pixel,
    input  wire logic            i_has_pixel,
    input  wire logic            i_end_of_row,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [WORD_W-1:0]    o_packed_bytes,
    output logic [CNT_W-1:0]     o_byte_count,
    output logic                 o_last
);

    logic [IN_W-1:0]   r_px;
    logic              r_has;
    logic              r_eor;
    logic [ZP_W-1:0]   r_zp, n_zp;
    logic [LIT_AW-1:0] r_cnt, n_cnt;
    logic [LIT_AW-1:0] r_idx, n_idx;
    logic [7:0]        r_mem [0:LIT_DEPTH-1];
    logic [7:0]        r_rd_data;
    logic [WORD_W-1:0] r_word, n_word;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic              r_out_last, n_out_last;
    logic              out_free;
    logic              fire;
    logic [LIT_AW-1:0] zero_k;
    logic [7:0]        byte_val;

    // hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_px  <= i_pixel;
            r_has <= i_has_pixel;
            r_eor <= i_end_of_row;
        end
    end

    assign zero_k = (r_zp > ZP_RUN) ? RUN_MAX : r_zp[LIT_AW-1:0];

    always_comb begin
        case (i_cmd.src)
            SRC_ZERO:  byte_val = ZERO_FLAG | {1'b0, zero_k};
            SRC_COUNT: byte_val = {1'b0, r_cnt};
            SRC_DATA:  byte_val = r_rd_data;
            SRC_MARK:  byte_val = ZERO_FLAG;
            default:   byte_val = '0;
        endcase
    end

    always_comb begin
        n_zp = r_zp;
        if (i_cmd.zp_clr) begin
            n_zp = '0;
        end else if (i_cmd.zp_sub) begin
            n_zp = r_zp - ZP_W'(zero_k);
        end else if (i_cmd.zp_inc && (r_zp < ZP_CAP)) begin
            n_zp = r_zp + 1'b1;
        end

        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.store) begin
            n_cnt = r_cnt + 1'b1;
        end

        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zp  <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_zp  <= n_zp;
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    // literal memory: read data follows the next index
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_cnt] <= r_px;
        end
        r_rd_data <= r_mem[n_idx];
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign fire     = i_cmd.push && o_st.byte_ok;

    always_comb begin
        n_word      = r_word;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        if (fire) begin
            if ((r_fill == '0) || (r_fill == FILL_FULL)) begin
                n_word = {{(WORD_W-8){1'b0}}, byte_val};
                n_fill = 4'd1;
            end else begin
                n_word[{r_fill[2:0], 3'b000} +: 8] = byte_val;
                n_fill = r_fill + 1'b1;
            end
            if (r_fill == FILL_FULL) begin
                n_out_valid = 1'b1;
                n_out_data  = r_word;
                n_out_cnt   = FILL_FULL;
                n_out_last  = 1'b0;
            end
        end else if (i_cmd.close && (r_fill != '0) && out_free) begin
            n_fill      = '0;
            n_out_valid = 1'b1;
            n_out_data  = r_word;
            n_out_cnt   = r_fill;
            n_out_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_word     <= n_word;
        r_out_data <= n_out_data;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    always_comb begin
        o_st.has      = r_has;
        o_st.px_zero  = (r_px == '0);
        o_st.eor      = r_eor;
        o_st.zp_nz    = (r_zp != '0);
        o_st.zp_last  = (r_zp <= ZP_RUN);
        o_st.cnt_nz   = (r_cnt != '0);
        o_st.cnt_full = (r_cnt == RUN_MAX);
        o_st.idx_last = (r_idx == (r_cnt - 1'b1));
        o_st.byte_ok  = (r_fill != FILL_FULL) || out_free;
        o_st.close_ok = (r_fill == '0) || out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_packed_bytes = r_out_data;
    assign o_byte_count   = r_out_cnt;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire
